// ===== hw/rtl/fctld_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the
// front-coded term-list decoder. No dependencies.
package fctld_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int MAX_TERM_LEN = 255;
    localparam int VGROUPS      = (VALUE_BITS + 6) / 7;
    localparam int GROUP_W      = $clog2(VGROUPS + 1);
    localparam int SHIFT_W      = $clog2(7 * VGROUPS + 1);
    localparam int TDATA_W      = 56;
    localparam int TUSER_W      = 5;

    localparam logic [7:0] CONT_MASK    = 8'h80;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7f;

    localparam logic [1:0] KIND_LSIZE  = 2'd0;
    localparam logic [1:0] KIND_DOCLEN = 2'd1;
    localparam logic [1:0] KIND_HEAD   = 2'd2;
    localparam logic [1:0] KIND_SUFFIX = 2'd3;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_SHORT = 2'd1;
    localparam logic [1:0] FAULT_OVF   = 2'd2;
    localparam logic [1:0] FAULT_LONG  = 2'd3;

    localparam logic [2:0] OSEL_FAULT  = 3'd0;
    localparam logic [2:0] OSEL_EMPTY  = 3'd1;
    localparam logic [2:0] OSEL_LSIZE  = 3'd2;
    localparam logic [2:0] OSEL_DOCLEN = 3'd3;
    localparam logic [2:0] OSEL_HEAD   = 3'd4;
    localparam logic [2:0] OSEL_SUFFIX = 3'd5;

    typedef struct packed {
        logic       out_load;
        logic [2:0] osel;
        logic [1:0] kind;
        logic [1:0] fault;
        logic       vi_feed;
        logic       skip_from_hdr;
        logic       skip_from_vi;
        logic       skip_dec;
        logic       wdf_load;
        logic       term_from_byte;
        logic       term_clear;
        logic       div_start;
        logic       head_commit;
        logic       suffix_step;
        logic       rec_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic hdr_slot;
        logic hdr_len_zero;
        logic byte_zero;
        logic vi_done;
        logic vi_ovf;
        logic vi_zero;
        logic vi_max;
        logic skip_last;
        logic have_term;
        logic reuse_packed;
        logic too_long;
        logic suffix_last;
        logic div_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/front_coded_term_list_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the front-coded term-list decoder: controller plus datapath.
// Depends on fctld_pkg, fctld_ctrl and fctld_dp.
//
// Takes one record byte per transfer and gives at most one result per byte:
// list size, document length, term head (kept prefix, wdf, append count) or
// suffix byte, with faults reported in place of the result. A reuse byte that
// packs the wdf gets its quotient and remainder from an eight-step restoring
// divider, and the input stalls while that divider runs. The result register
// frees as soon as the output side takes its transfer; the input also stalls
// while a result is still held and the output side is not ready.
module front_coded_term_list_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // in_byte
    input  logic                            s_tlast,   // record_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fctld_pkg::TDATA_W-1:0]   m_tdata,   // value, keep_len, append_len, suffix_byte
    output logic [fctld_pkg::TUSER_W-1:0]   m_tuser,   // kind, term_done, fault
    output logic                            m_tlast    // list_done
);
    import fctld_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    fctld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fctld_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== hw/rtl/fctld_dp.sv =====
`timescale 1ns / 1ps
// Datapath: varint accumulator, skip and suffix counters, term length,
// reuse-byte divider and the output register. Depends on fctld_pkg.
module fctld_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  fctld_pkg::dp_cmd_t              cmd,
    output fctld_pkg::dp_status_t           sts,
    output logic [fctld_pkg::TDATA_W-1:0]   m_tdata,
    output logic [fctld_pkg::TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import fctld_pkg::*;

    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_fed;
    logic [GROUP_W-1:0]    grp_reg, grp_next;
    logic [VALUE_BITS-1:0] skip_reg, skip_next;
    logic [7:0]            term_len_reg, term_len_next;
    logic                  have_term_reg, have_term_next;
    logic [VALUE_BITS-1:0] pend_reg, pend_next;
    logic [7:0]            sfx_left_reg, sfx_left_next;

    logic                  div_busy_reg, div_busy_next;
    logic [2:0]            div_cnt_reg, div_cnt_next;
    logic [7:0]            dvd_reg, dvd_next;
    logic [7:0]            rem_reg, rem_next;
    logic [7:0]            quo_reg, quo_next;
    logic [8:0]            dsr_reg, dsr_next;

    logic [6:0]            payload;
    logic [SHIFT_W-1:0]    shamt;
    logic [VALUE_BITS+6:0] placed;
    logic                  in_range;
    logic [8:0]            trial;
    logic                  ge;
    logic [8:0]            trial_sub;
    logic [7:0]            quo_fin;
    logic [8:0]            len_sum;

    logic [VALUE_BITS-1:0] o_value;
    logic [7:0]            o_keep, o_app, o_sfx;
    logic                  o_tdone, o_ldone;

    assign payload  = s_tdata[6:0];
    assign shamt    = {grp_reg, 3'b000} - SHIFT_W'(grp_reg);
    assign placed   = (VALUE_BITS + 7)'(payload) << shamt;
    assign in_range = grp_reg < GROUP_W'(VGROUPS);
    assign acc_fed  = in_range ? (acc_reg | placed[VALUE_BITS-1:0]) : acc_reg;

    assign trial     = {rem_reg, dvd_reg[7]};
    assign ge        = trial >= dsr_reg;
    assign trial_sub = trial - dsr_reg;
    assign quo_fin   = {quo_reg[6:0], ge};
    assign len_sum   = {1'b0, term_len_reg} + {1'b0, s_tdata};

    always_comb
    begin
        sts.hdr_slot     = (s_tdata & CONT_MASK) != 8'h00;
        sts.hdr_len_zero = (s_tdata & PAYLOAD_MASK) == 8'h00;
        sts.byte_zero    = s_tdata == 8'h00;
        sts.vi_done      = (s_tdata & CONT_MASK) == 8'h00;
        sts.vi_ovf       = in_range ? (|placed[VALUE_BITS+6:VALUE_BITS]) : (payload != 7'd0);
        sts.vi_zero      = acc_fed == '0;
        sts.vi_max       = &acc_fed;
        sts.skip_last    = skip_reg <= VALUE_BITS'(1);
        sts.have_term    = have_term_reg;
        sts.reuse_packed = s_tdata > term_len_reg;
        sts.too_long     = len_sum > 9'(MAX_TERM_LEN);
        sts.suffix_last  = sfx_left_reg <= 8'd1;
        sts.div_busy     = div_busy_reg;
    end

    always_comb
    begin
        acc_next       = acc_reg;
        grp_next       = grp_reg;
        skip_next      = skip_reg;
        term_len_next  = term_len_reg;
        have_term_next = have_term_reg;
        pend_next      = pend_reg;
        sfx_left_next  = sfx_left_reg;
        div_busy_next  = div_busy_reg;
        div_cnt_next   = div_cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dsr_next       = dsr_reg;

        if (cmd.vi_feed)
        begin
            if (sts.vi_done)
            begin
                acc_next = '0;
                grp_next = '0;
            end
            else
            begin
                acc_next = acc_fed;
                grp_next = in_range ? grp_reg + GROUP_W'(1) : grp_reg;
            end
        end
        if (cmd.skip_from_hdr)
            skip_next = VALUE_BITS'(s_tdata & PAYLOAD_MASK);
        if (cmd.skip_from_vi)
            skip_next = acc_fed;
        if (cmd.skip_dec && skip_reg != '0)
            skip_next = skip_reg - VALUE_BITS'(1);
        if (cmd.wdf_load)
            pend_next = acc_fed;
        if (cmd.term_clear)
            term_len_next = 8'd0;
        if (cmd.term_from_byte)
            term_len_next = s_tdata;
        if (cmd.div_start)
        begin
            div_busy_next = 1'b1;
            div_cnt_next  = 3'd0;
            dvd_next      = s_tdata;
            rem_next      = 8'd0;
            quo_next      = 8'd0;
            dsr_next      = {1'b0, term_len_reg} + 9'd1;
        end
        else if (div_busy_reg)
        begin
            dvd_next     = {dvd_reg[6:0], 1'b0};
            rem_next     = ge ? trial_sub[7:0] : trial[7:0];
            quo_next     = quo_fin;
            div_cnt_next = div_cnt_reg + 3'd1;
            if (div_cnt_reg == 3'd7)
            begin
                div_busy_next = 1'b0;
                term_len_next = ge ? trial_sub[7:0] : trial[7:0];
                pend_next     = VALUE_BITS'(quo_fin) - VALUE_BITS'(1);
            end
        end
        if (cmd.head_commit)
        begin
            if (sts.byte_zero)
                have_term_next = term_len_reg != 8'd0;
            else
                sfx_left_next = s_tdata;
        end
        if (cmd.suffix_step)
        begin
            if (sfx_left_reg != 8'd0)
                sfx_left_next = sfx_left_reg - 8'd1;
            term_len_next = term_len_reg + 8'd1;
            if (sts.suffix_last)
                have_term_next = 1'b1;
        end
        if (cmd.rec_clear)
        begin
            acc_next       = '0;
            grp_next       = '0;
            skip_next      = '0;
            term_len_next  = 8'd0;
            have_term_next = 1'b0;
            pend_next      = '0;
            sfx_left_next  = 8'd0;
            div_busy_next  = 1'b0;
        end
    end

    always_comb
    begin
        o_value = '0;
        o_keep  = 8'd0;
        o_app   = 8'd0;
        o_sfx   = 8'd0;
        o_tdone = 1'b0;
        o_ldone = 1'b0;
        case (cmd.osel)
            OSEL_EMPTY:
                o_ldone = 1'b1;
            OSEL_LSIZE:
                o_value = acc_fed + VALUE_BITS'(1);
            OSEL_DOCLEN:
            begin
                o_value = acc_fed;
                o_ldone = s_tlast;
            end
            OSEL_HEAD:
            begin
                o_value = pend_reg;
                o_keep  = term_len_reg;
                o_app   = s_tdata;
                o_tdone = sts.byte_zero;
                o_ldone = s_tlast && sts.byte_zero;
            end
            OSEL_SUFFIX:
            begin
                o_sfx   = s_tdata;
                o_tdone = sts.suffix_last;
                o_ldone = s_tlast && sts.suffix_last;
            end
            default:
                o_value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            grp_reg       <= '0;
            skip_reg      <= '0;
            term_len_reg  <= 8'd0;
            have_term_reg <= 1'b0;
            pend_reg      <= '0;
            sfx_left_reg  <= 8'd0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= 3'd0;
        end
        else
        begin
            acc_reg       <= acc_next;
            grp_reg       <= grp_next;
            skip_reg      <= skip_next;
            term_len_reg  <= term_len_next;
            have_term_reg <= have_term_next;
            pend_reg      <= pend_next;
            sfx_left_reg  <= sfx_left_next;
            div_busy_reg  <= div_busy_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        if (cmd.out_load)
        begin
            m_tdata <= {o_sfx, o_app, o_keep, o_value[31:0]};
            m_tuser <= {cmd.fault, o_tdone, cmd.kind};
            m_tlast <= o_ldone;
        end
    end

endmodule

// ===== hw/rtl/fctld_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: record parse state machine and stream handshakes; drives
// datapath commands from datapath status. Depends on fctld_pkg.
module fctld_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  fctld_pkg::dp_status_t sts,
    output fctld_pkg::dp_cmd_t    cmd
);
    import fctld_pkg::*;

    localparam logic [3:0] PH_HEAD    = 4'd0;
    localparam logic [3:0] PH_SLOTLEN = 4'd1;
    localparam logic [3:0] PH_SKIP    = 4'd2;
    localparam logic [3:0] PH_LSIZE   = 4'd3;
    localparam logic [3:0] PH_DOCLEN  = 4'd4;
    localparam logic [3:0] PH_TERM    = 4'd5;
    localparam logic [3:0] PH_WDF     = 4'd6;
    localparam logic [3:0] PH_APPEND  = 4'd7;
    localparam logic [3:0] PH_SUFFIX  = 4'd8;
    localparam logic [3:0] PH_DEAD    = 4'd9;
    localparam logic [3:0] PH_DIV     = 4'd10;

    logic [3:0] phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    assign s_tready = (phase_reg != PH_DIV) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cmd        = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (sts.hdr_slot)
                    begin
                        phase_next        = sts.hdr_len_zero ? PH_SLOTLEN : PH_SKIP;
                        cmd.skip_from_hdr = !sts.hdr_len_zero;
                        if (s_tlast)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_FAULT;
                            cmd.kind     = KIND_LSIZE;
                            cmd.fault    = FAULT_SHORT;
                        end
                    end
                    else
                    begin
                        phase_next = PH_LSIZE;
                        if (s_tlast)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_EMPTY;
                            cmd.kind     = KIND_LSIZE;
                        end
                    end
                end
                PH_SLOTLEN:
                begin
                    cmd.vi_feed = 1'b1;
                    if (sts.vi_ovf)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_LSIZE;
                        cmd.fault    = FAULT_OVF;
                        phase_next   = PH_DEAD;
                    end
                    else if (sts.vi_done && sts.vi_zero)
                    begin
                        phase_next = PH_LSIZE;
                        if (s_tlast)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_EMPTY;
                            cmd.kind     = KIND_LSIZE;
                        end
                    end
                    else
                    begin
                        if (sts.vi_done)
                        begin
                            cmd.skip_from_vi = 1'b1;
                            phase_next       = PH_SKIP;
                        end
                        if (s_tlast)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_FAULT;
                            cmd.kind     = KIND_LSIZE;
                            cmd.fault    = FAULT_SHORT;
                        end
                    end
                end
                PH_SKIP:
                begin
                    cmd.skip_dec = 1'b1;
                    if (sts.skip_last)
                    begin
                        phase_next = PH_LSIZE;
                        if (s_tlast)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_EMPTY;
                            cmd.kind     = KIND_LSIZE;
                        end
                    end
                    else if (s_tlast)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_LSIZE;
                        cmd.fault    = FAULT_SHORT;
                    end
                end
                PH_LSIZE:
                begin
                    cmd.vi_feed = 1'b1;
                    if (sts.vi_ovf || (sts.vi_done && sts.vi_max))
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_LSIZE;
                        cmd.fault    = FAULT_OVF;
                        phase_next   = PH_DEAD;
                    end
                    else if (s_tlast)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_LSIZE;
                        cmd.fault    = FAULT_SHORT;
                    end
                    else if (sts.vi_done)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_LSIZE;
                        cmd.kind     = KIND_LSIZE;
                        phase_next   = PH_DOCLEN;
                    end
                end
                PH_DOCLEN:
                begin
                    cmd.vi_feed = 1'b1;
                    if (sts.vi_ovf)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_DOCLEN;
                        cmd.fault    = FAULT_OVF;
                        phase_next   = PH_DEAD;
                    end
                    else if (sts.vi_done)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_DOCLEN;
                        cmd.kind     = KIND_DOCLEN;
                        phase_next   = PH_TERM;
                    end
                    else if (s_tlast)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_DOCLEN;
                        cmd.fault    = FAULT_SHORT;
                    end
                end
                PH_TERM, PH_WDF:
                begin
                    if (phase_reg == PH_TERM && sts.have_term)
                    begin
                        if (s_tlast)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_FAULT;
                            cmd.kind     = KIND_HEAD;
                            cmd.fault    = FAULT_SHORT;
                        end
                        else if (sts.reuse_packed)
                        begin
                            cmd.div_start = 1'b1;
                            phase_next    = PH_DIV;
                        end
                        else
                        begin
                            cmd.term_from_byte = 1'b1;
                            phase_next         = PH_WDF;
                        end
                    end
                    else
                    begin
                        cmd.term_clear = (phase_reg == PH_TERM);
                        cmd.vi_feed    = 1'b1;
                        phase_next     = PH_WDF;
                        if (sts.vi_ovf)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_FAULT;
                            cmd.kind     = KIND_HEAD;
                            cmd.fault    = FAULT_OVF;
                            phase_next   = PH_DEAD;
                        end
                        else
                        begin
                            if (sts.vi_done)
                            begin
                                cmd.wdf_load = 1'b1;
                                phase_next   = PH_APPEND;
                            end
                            if (s_tlast)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.osel     = OSEL_FAULT;
                                cmd.kind     = KIND_HEAD;
                                cmd.fault    = FAULT_SHORT;
                            end
                        end
                    end
                end
                PH_APPEND:
                begin
                    if (sts.too_long)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_HEAD;
                        cmd.fault    = FAULT_LONG;
                        phase_next   = PH_DEAD;
                    end
                    else if (!sts.byte_zero && s_tlast)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_HEAD;
                        cmd.fault    = FAULT_SHORT;
                    end
                    else
                    begin
                        cmd.out_load    = 1'b1;
                        cmd.osel        = OSEL_HEAD;
                        cmd.kind        = KIND_HEAD;
                        cmd.head_commit = 1'b1;
                        phase_next      = sts.byte_zero ? PH_TERM : PH_SUFFIX;
                    end
                end
                PH_SUFFIX:
                begin
                    if (!sts.suffix_last && s_tlast)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.osel     = OSEL_FAULT;
                        cmd.kind     = KIND_SUFFIX;
                        cmd.fault    = FAULT_SHORT;
                    end
                    else
                    begin
                        cmd.out_load    = 1'b1;
                        cmd.osel        = OSEL_SUFFIX;
                        cmd.kind        = KIND_SUFFIX;
                        cmd.suffix_step = 1'b1;
                        if (sts.suffix_last)
                            phase_next = PH_TERM;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase
            if (s_tlast)
            begin
                phase_next    = PH_HEAD;
                cmd.rec_clear = 1'b1;
            end
        end
        else if (phase_reg == PH_DIV && !sts.div_busy)
        begin
            phase_next = PH_APPEND;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIV |-> !s_tready)
        else $error("byte taken while divider runs");

    a_end_to_head: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> phase_reg == PH_HEAD)
        else $error("record end did not return to header");

    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> accept && (!m_tvalid_reg || m_tready))
        else $error("result loaded without a byte transfer");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIV && !sts.div_busy |=> phase_reg == PH_APPEND)
        else $error("divider finish did not advance to append count");

endmodule
